/* design/lfo_waveform_generator_defines.svh */
// Assertion macros for the low-frequency oscillator.
// Included by the top level; no other dependencies.
`ifndef LFO_WAVEFORM_GENERATOR_DEFINES_SVH
`define LFO_WAVEFORM_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LFO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LFO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LFO_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LFO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/lfo_pkg.sv */
// Shared constants, types and the quarter-wave sine table of the oscillator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int OUTPUT_BITS     = 16;
    localparam int SINE_TABLE_BITS = 8;

    localparam int INC_BITS  = 32;
    localparam int SINE_N    = 1 << SINE_TABLE_BITS;
    localparam int INC_SHL   = (PHASE_BITS >= INC_BITS) ? PHASE_BITS - INC_BITS : 0;
    localparam int INC_SHR   = (PHASE_BITS < INC_BITS) ? INC_BITS - PHASE_BITS : 0;
    localparam int ADDR_BITS = 3;

    typedef enum logic [1:0] {
        WAVE_SAW      = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SINE     = 2'd3
    } t_wave;

    // Register index, taken from paddr bit 2.
    localparam logic REG_WAVE_SELECT     = 1'b0;
    localparam logic REG_PHASE_INCREMENT = 1'b1;

    typedef logic [OUTPUT_BITS-2:0] t_sine_tab [0:SINE_N];

    // Truncating Horner series for sin(x) in unsigned Q2.30, scaled to the
    // output format with round half up and saturated below +1.
    function automatic t_sine_tab f_build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] h;
        logic [63:0] q30_one;
        for (int k = 0; k <= SINE_N; k++) begin
            q30_one = 64'd1 << 30;
            h       = 64'd1 << (OUTPUT_BITS - 1);
            x       = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
            x2      = (x * x) >> 30;
            t       = q30_one;
            t       = q30_one - (((x2 * t) >> 30) / 64'd156);
            t       = q30_one - (((x2 * t) >> 30) / 64'd110);
            t       = q30_one - (((x2 * t) >> 30) / 64'd72);
            t       = q30_one - (((x2 * t) >> 30) / 64'd42);
            t       = q30_one - (((x2 * t) >> 30) / 64'd20);
            t       = q30_one - (((x2 * t) >> 30) / 64'd6);
            s       = (x * t) >> 30;
            v       = (s * h + (64'd1 << 29)) >> 30;
            if (v > h - 64'd1) begin
                v = h - 64'd1;
            end
            tab[k] = v[OUTPUT_BITS-2:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_sine_tab();

endpackage

`default_nettype wire

/* design/lfo_waveform_generator.sv */
// Low-frequency oscillator: a phase accumulator that turns each tick word into
// one signed Q1.15 sample (saw, triangle, square or quarter-wave sine) and then
// advances the phase by the programmed increment. An accepted word goes straight
// into the output register, and one word is accepted every cycle; the
// only thing that holds the input is a stalled result in the output register.
// A tick word of zero is accepted but yields no sample and leaves the phase.
// Uses lfo_pkg and the assertion macros in lfo_waveform_generator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lfo_waveform_generator_defines.svh"

module lfo_waveform_generator (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // APB configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [lfo_pkg::ADDR_BITS-1:0]         paddr,
    input  wire logic [31:0]                           pwdata,
    output logic      [31:0]                           prdata,
    output logic                                       pready,
    // tick input
    input  wire logic                                  i_valid,
    input  wire logic                                  i_tick,
    output logic                                       o_stall,
    // sample output
    output logic                                       o_valid,
    output logic signed [lfo_pkg::OUTPUT_BITS-1:0]     o_sample_value,
    input  wire logic                                  i_stall
);
    import lfo_pkg::*;

    localparam int M = OUTPUT_BITS;
    localparam int S = SINE_TABLE_BITS;

    t_wave                   r_wave;
    logic [INC_BITS-1:0]     r_inc;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [PHASE_BITS-1:0]   n_phase;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic signed [M-1:0]     r_sample;
    logic signed [M-1:0]     n_sample;

    logic                    cfg_write;
    logic                    accept;
    logic [PHASE_BITS-1:0]   inc_aligned;

    logic [M-1:0]            q;
    logic [M:0]              tri_dist;
    logic signed [M+1:0]     tri_full;
    logic [S+1:0]            sine_top;
    logic [S:0]              sine_idx;
    logic [M-1:0]            sine_mag;
    logic signed [M-1:0]     wave_val;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_PHASE_INCREMENT) ? r_inc : {30'd0, r_wave};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= WAVE_SAW;
            r_inc  <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_WAVE_SELECT) begin
                r_wave <= t_wave'(pwdata[1:0]);
            end else begin
                r_inc <= pwdata;
            end
        end
    end

    // The output register is the only stage, so the input stalls only while
    // a result sits there and the far side is stalling.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign inc_aligned = PHASE_BITS'(({{PHASE_BITS{1'b0}}, r_inc} << INC_SHL) >> INC_SHR);

    // Waveform from the current phase.
    always_comb begin
        q        = r_phase[PHASE_BITS-1 -: M];
        tri_dist = q[M-1] ? ({1'b0, q} - (M+1)'(1 << (M - 1)))
                          : ((M+1)'(1 << (M - 1)) - {1'b0, q});
        tri_full = $signed({1'b0, (M+1)'(1 << (M - 1))})
                 - $signed({1'b0, tri_dist[M-1:0], 1'b0});
        sine_top = r_phase[PHASE_BITS-1 -: S+2];
        sine_idx = sine_top[S] ? ((S+1)'(SINE_N) - {1'b0, sine_top[S-1:0]})
                               : {1'b0, sine_top[S-1:0]};
        sine_mag = {1'b0, SINE_TAB[sine_idx]};
        case (r_wave)
            WAVE_SAW: begin
                wave_val = $signed({~q[M-1], q[M-2:0]});
            end
            WAVE_TRIANGLE: begin
                // The peak of +1 only occurs at mid cycle and saturates.
                if (tri_dist == '0) begin
                    wave_val = $signed({1'b0, {(M-1){1'b1}}});
                end else begin
                    wave_val = tri_full[M-1:0];
                end
            end
            WAVE_SQUARE: begin
                wave_val = q[M-1] ? $signed({1'b1, {(M-1){1'b0}}})
                                  : $signed({1'b0, {(M-1){1'b1}}});
            end
            WAVE_SINE: begin
                wave_val = sine_top[S+1] ? $signed(-sine_mag) : $signed(sine_mag);
            end
            default: begin
                wave_val = '0;
            end
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_out_valid = r_out_valid && i_stall;
        n_sample    = r_sample;
        if (accept && i_tick) begin
            n_phase     = r_phase + inc_aligned;
            n_out_valid = 1'b1;
            n_sample    = wave_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = r_sample;

    `LFO_ASSERT_NEXT(a_tick_gives_sample, i_clk, i_rst_n, accept && i_tick, o_valid)
    `LFO_ASSERT_NEXT(a_phase_holds, i_clk, i_rst_n, !(accept && i_tick), $stable(r_phase))
    `LFO_ASSERT_NEXT(a_phase_steps, i_clk, i_rst_n, accept && i_tick,
                     r_phase == $past(r_phase) + $past(inc_aligned))
    `LFO_ASSERT_SAME(a_no_accept_on_stall, i_clk, i_rst_n, o_valid && i_stall, !accept)

endmodule

`default_nettype wire
